>>> rtl/core/best_fit_partition_allocator_top_assert.svh
// Assertion macros for the partition allocator
`ifndef BEST_FIT_PARTITION_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_TOP_ASSERT_SVH

// implication check, disabled in reset
`define BFPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, disabled in reset
`define BFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

>>> rtl/core/bfpa_pkg.sv
package bfpa_pkg;

    localparam int ADDR_BITS    = 16;
    localparam int ID_BITS      = 8;
    localparam int FREE_ENTRIES = 17;
    localparam int BUSY_ENTRIES = 16;
    localparam int QUEUE_DEPTH  = 8;
    localparam int LEN_BITS     = ADDR_BITS + 1;
    localparam int FIDX_BITS    = $clog2(FREE_ENTRIES);
    localparam int BIDX_BITS    = $clog2(BUSY_ENTRIES);
    localparam int QIDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FCNT_BITS    = $clog2(FREE_ENTRIES + 1);
    localparam int BCNT_BITS    = $clog2(BUSY_ENTRIES + 1);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [LEN_BITS-1:0]  t_len;
    typedef logic [ID_BITS-1:0]   t_id;

    typedef enum logic [2:0] {
        KIND_GRANT   = 3'd0,
        KIND_QUEUED  = 3'd1,
        KIND_FREED   = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_DROPPED = 3'd4
    } t_kind;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,      // reset tables
        CMD_LOAD,      // latch request
        CMD_FIT_STEP,  // scan one free entry for best fit
        CMD_GRANT,     // commit grant into tables
        CMD_ENQUEUE,   // push request into queue
        CMD_BSRCH,     // scan one busy entry for id
        CMD_RELEASE,   // remove busy entry
        CMD_ADJ_STEP,  // scan one free entry for neighbors
        CMD_MERGE,     // coalesce
        CMD_QSCAN,     // scan one queue entry
        CMD_QPICK,     // load queued request as current
        CMD_QPOP       // remove granted queue entry
    } t_cmd;

    typedef struct packed {
        logic fit_found;
        logic busy_full;
        logic queue_full;
        logic fscan_done;
        logic bscan_done;
        logic bhit;
        logic qscan_done;
        logic qfit;
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ALLOC_SCAN, ST_ALLOC_DEC, ST_BUSY_SCAN, ST_RELEASE,
        ST_ADJ_SCAN, ST_MERGE, ST_Q_SCAN, ST_Q_FIT_SCAN, ST_Q_DEC, ST_OUT1, ST_OUT2
    } t_state;

endpackage

>>> rtl/core/bfpa_datapath.sv
module bfpa_datapath
    import bfpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_scan_rst,
    input  logic      i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_data,
    input  t_id       i_id,
    input  t_len      i_size,
    output t_status   o_status,
    output t_id       o_cur_id,
    output t_addr     o_gb,
    output t_addr     o_ge,
    output t_id       o_free_id,
    output t_addr     o_fb,
    output t_addr     o_fe
);
    // tables (small, register arrays)
    t_addr r_fr_b [FREE_ENTRIES];
    t_addr r_fr_e [FREE_ENTRIES];
    t_id   r_bz_id [BUSY_ENTRIES];
    t_addr r_bz_b [BUSY_ENTRIES];
    t_addr r_bz_e [BUSY_ENTRIES];
    t_id   r_wq_id [QUEUE_DEPTH];
    t_len  r_wq_sz [QUEUE_DEPTH];
    logic [FCNT_BITS-1:0] r_fcnt;
    logic [BCNT_BITS-1:0] r_bcnt;
    logic [QCNT_BITS-1:0] r_qcnt;
    t_len  r_msize;

    // working registers
    t_id   r_cur_id;
    t_len  r_cur_sz;
    logic [FCNT_BITS-1:0] r_fi;
    logic [BCNT_BITS-1:0] r_bi;
    logic [QCNT_BITS-1:0] r_qi;
    logic  r_found;
    logic [FIDX_BITS-1:0] r_best;
    t_len  r_waste;
    logic  r_bhit;
    logic [BIDX_BITS-1:0] r_bidx;
    t_id   r_fid;
    t_addr r_fb, r_fe;
    logic  r_up, r_dn;
    logic [FIDX_BITS-1:0] r_upi, r_dni;
    t_len  r_mlen;
    logic  r_qfit;
    logic [QIDX_BITS-1:0] r_qk;
    t_addr r_gb, r_ge;

    logic [FIDX_BITS-1:0] fi;
    logic [BIDX_BITS-1:0] bi;
    logic [QIDX_BITS-1:0] qi;
    t_len  len_i, waste_i;
    t_addr gend;
    t_len  cfg_v;

    assign fi = r_fi[FIDX_BITS-1:0];
    assign bi = r_bi[BIDX_BITS-1:0];
    assign qi = r_qi[QIDX_BITS-1:0];
    assign len_i   = t_len'({1'b0, r_fr_e[fi]} - {1'b0, r_fr_b[fi]} + 1'b1);
    assign waste_i = len_i - r_cur_sz;
    assign gend    = t_addr'(r_fr_b[r_best] + r_cur_sz[ADDR_BITS-1:0] - 1'b1);

    // config value clamp
    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v == '0) cfg_v = t_len'(1);
        if (cfg_v > (t_len'(1) << ADDR_BITS)) cfg_v = t_len'(1) << ADDR_BITS;
    end

    always_comb begin
        o_status.fit_found  = r_found;
        o_status.busy_full  = (r_bcnt >= BCNT_BITS'(BUSY_ENTRIES));
        o_status.queue_full = (r_qcnt >= QCNT_BITS'(QUEUE_DEPTH));
        o_status.fscan_done = (r_fi >= r_fcnt);
        o_status.bscan_done = (r_bi >= r_bcnt) || r_bhit;
        o_status.bhit       = r_bhit;
        o_status.qscan_done = (r_qi >= r_qcnt) || r_qfit;
        o_status.qfit       = r_qfit;
    end
    assign o_cur_id  = r_cur_id;
    assign o_gb      = r_gb;
    assign o_ge      = r_ge;
    assign o_free_id = r_fid;
    assign o_fb      = r_fb;
    assign o_fe      = r_fe;

    always_ff @(posedge i_clk) begin
        if (i_scan_rst) begin
            r_fi <= '0; r_bi <= '0; r_qi <= '0;
            r_found <= 1'b0; r_bhit <= 1'b0; r_up <= 1'b0; r_dn <= 1'b0;
            r_qfit <= 1'b0;
        end
        // memory size register, full memory after reset
        if (!i_rst_n) begin
            r_msize <= t_len'(1) << ADDR_BITS;
        end else if (i_cfg_we) begin
            r_msize <= cfg_v;
        end
        unique case (i_cmd)
            CMD_INIT: begin
                r_fcnt <= FCNT_BITS'(1);
                r_fr_b[0] <= '0;
                r_fr_e[0] <= t_addr'(r_msize - 1'b1);
                r_bcnt <= '0;
                r_qcnt <= '0;
            end
            CMD_LOAD: begin
                r_cur_id <= i_id;
                r_cur_sz <= (i_size == '0) ? t_len'(1) : i_size;
                r_fid <= i_id;
            end
            CMD_FIT_STEP: begin
                if (r_cur_sz <= len_i && (!r_found || waste_i < r_waste)) begin
                    r_found <= 1'b1;
                    r_best  <= fi;
                    r_waste <= waste_i;
                end
                r_fi <= r_fi + 1'b1;
            end
            CMD_GRANT: begin
                // shrink or remove the region
                if (r_waste != '0) begin
                    r_fr_b[r_best] <= t_addr'(gend + 1'b1);
                end else begin
                    for (int j = 0; j < FREE_ENTRIES - 1; j++)
                        if (FIDX_BITS'(j) >= r_best && FCNT_BITS'(j + 1) < r_fcnt) begin
                            r_fr_b[j] <= r_fr_b[j+1];
                            r_fr_e[j] <= r_fr_e[j+1];
                        end
                    r_fcnt <= r_fcnt - 1'b1;
                end
                // ordered insert into busy table
                for (int j = 0; j < BUSY_ENTRIES; j++) begin
                    if (BCNT_BITS'(j) <= r_bcnt) begin
                        if (j > 0 && r_bz_b[j-1] > gend) begin
                            r_bz_id[j] <= r_bz_id[j-1];
                            r_bz_b[j]  <= r_bz_b[j-1];
                            r_bz_e[j]  <= r_bz_e[j-1];
                        end else if ((j == 0 || r_bz_b[j-1] <= gend) &&
                                     (BCNT_BITS'(j) == r_bcnt || r_bz_b[j] > gend)) begin
                            r_bz_id[j] <= r_cur_id;
                            r_bz_b[j]  <= r_fr_b[r_best];
                            r_bz_e[j]  <= gend;
                        end
                    end
                end
                r_bcnt <= r_bcnt + 1'b1;
                r_gb <= r_fr_b[r_best];
                r_ge <= gend;
            end
            CMD_ENQUEUE: begin
                r_wq_id[r_qcnt[QIDX_BITS-1:0]] <= r_cur_id;
                r_wq_sz[r_qcnt[QIDX_BITS-1:0]] <= r_cur_sz;
                r_qcnt <= r_qcnt + 1'b1;
            end
            CMD_BSRCH: begin
                if (r_bz_id[bi] == r_fid) begin
                    r_bhit <= 1'b1;
                    r_bidx <= bi;
                    r_fb   <= r_bz_b[bi];
                    r_fe   <= r_bz_e[bi];
                end else begin
                    r_bi <= r_bi + 1'b1;
                end
            end
            CMD_RELEASE: begin
                for (int j = 0; j < BUSY_ENTRIES - 1; j++)
                    if (BIDX_BITS'(j) >= r_bidx && BCNT_BITS'(j + 1) < r_bcnt) begin
                        r_bz_id[j] <= r_bz_id[j+1];
                        r_bz_b[j]  <= r_bz_b[j+1];
                        r_bz_e[j]  <= r_bz_e[j+1];
                    end
                r_bcnt <= r_bcnt - 1'b1;
            end
            CMD_ADJ_STEP: begin
                if ({1'b0, r_fr_e[fi]} + 1'b1 == {1'b0, r_fb}) begin
                    r_up <= 1'b1; r_upi <= fi;
                end else if ({1'b0, r_fr_b[fi]} == {1'b0, r_fe} + 1'b1) begin
                    r_dn <= 1'b1; r_dni <= fi;
                end
                r_fi <= r_fi + 1'b1;
            end
            CMD_MERGE: begin
                if (r_up && r_dn) begin
                    r_fr_e[r_upi] <= r_fr_e[r_dni];
                    r_mlen <= t_len'({1'b0, r_fr_e[r_dni]} - {1'b0, r_fr_b[r_upi]} + 1'b1);
                    for (int j = 0; j < FREE_ENTRIES - 1; j++)
                        if (FIDX_BITS'(j) >= r_dni && FCNT_BITS'(j + 1) < r_fcnt) begin
                            if (FIDX_BITS'(j) != r_upi || j + 1 != int'(r_dni)) begin
                                r_fr_b[j] <= r_fr_b[j+1];
                                r_fr_e[j] <= r_fr_e[j+1];
                            end
                        end
                    r_fcnt <= r_fcnt - 1'b1;
                end else if (r_up) begin
                    r_fr_e[r_upi] <= r_fe;
                    r_mlen <= t_len'({1'b0, r_fe} - {1'b0, r_fr_b[r_upi]} + 1'b1);
                end else if (r_dn) begin
                    r_fr_b[r_dni] <= r_fb;
                    r_mlen <= t_len'({1'b0, r_fr_e[r_dni]} - {1'b0, r_fb} + 1'b1);
                end else begin
                    r_mlen <= t_len'({1'b0, r_fe} - {1'b0, r_fb} + 1'b1);
                    if (r_fcnt < FCNT_BITS'(FREE_ENTRIES)) begin
                        for (int j = 0; j < FREE_ENTRIES; j++) begin
                            if (FCNT_BITS'(j) <= r_fcnt) begin
                                if (j > 0 && r_fr_b[j-1] > r_fe) begin
                                    r_fr_b[j] <= r_fr_b[j-1];
                                    r_fr_e[j] <= r_fr_e[j-1];
                                end else if ((j == 0 || r_fr_b[j-1] <= r_fe) &&
                                    (FCNT_BITS'(j) == r_fcnt || r_fr_b[j] > r_fe)) begin
                                    r_fr_b[j] <= r_fb;
                                    r_fr_e[j] <= r_fe;
                                end
                            end
                        end
                        r_fcnt <= r_fcnt + 1'b1;
                    end
                end
            end
            CMD_QSCAN: begin
                if (r_wq_sz[qi] <= r_mlen) begin
                    r_qfit <= 1'b1;
                    r_qk <= qi;
                end else begin
                    r_qi <= r_qi + 1'b1;
                end
            end
            CMD_QPICK: begin
                r_cur_id <= r_wq_id[r_qk];
                r_cur_sz <= r_wq_sz[r_qk];
            end
            CMD_QPOP: begin
                for (int j = 0; j < QUEUE_DEPTH - 1; j++)
                    if (QIDX_BITS'(j) >= r_qk && QCNT_BITS'(j + 1) < r_qcnt) begin
                        r_wq_id[j] <= r_wq_id[j+1];
                        r_wq_sz[j] <= r_wq_sz[j+1];
                    end
                r_qcnt <= r_qcnt - 1'b1;
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/core/bfpa_ctrl.sv
module bfpa_ctrl
    import bfpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_in_valid,
    input  logic    i_in_mode,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd,
    output logic    o_scan_rst,
    output logic    o_out_valid,
    output t_kind   o_kind,
    output logic    o_use_free,
    output logic    o_addr_en,
    output logic    o_last
);
    t_state r_state, n_state;
    logic   r_init, n_init;
    logic   r_mode, n_mode;
    logic   r_qmode, n_qmode;
    logic   r_drop, n_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_init <= 1'b1; r_mode <= 1'b0; r_qmode <= 1'b0;
            r_drop <= 1'b0;
        end else begin
            r_state <= n_state; r_init <= n_init; r_mode <= n_mode; r_qmode <= n_qmode;
            r_drop <= n_drop;
        end
    end

    always_comb begin
        n_state = r_state; n_init = r_init | i_cfg_we;
        n_mode = r_mode; n_qmode = r_qmode; n_drop = r_drop;
        o_in_ready = 1'b0; o_cmd = CMD_NONE; o_scan_rst = 1'b0;
        o_out_valid = 1'b0; o_kind = KIND_GRANT; o_use_free = 1'b0;
        o_addr_en = 1'b0; o_last = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_scan_rst = 1'b1;
                if (r_init) begin
                    o_cmd = CMD_INIT; n_init = i_cfg_we;
                end else begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd = CMD_LOAD; n_mode = i_in_mode; n_qmode = 1'b0;
                        n_state = i_in_mode ? ST_BUSY_SCAN : ST_ALLOC_SCAN;
                    end
                end
            end
            ST_ALLOC_SCAN: begin
                if (i_status.busy_full || i_status.fscan_done) n_state = ST_ALLOC_DEC;
                else o_cmd = CMD_FIT_STEP;
            end
            ST_ALLOC_DEC: begin
                if (!i_status.busy_full && i_status.fit_found) begin
                    o_cmd = CMD_GRANT;
                    n_state = r_qmode ? ST_OUT1 : ST_OUT2;
                end else if (r_qmode) begin
                    n_state = ST_OUT1; n_mode = 1'b0;
                    n_qmode = 1'b0;
                end else begin
                    // queue the request, or drop it when the queue is full
                    n_drop = i_status.queue_full;
                    if (!i_status.queue_full) o_cmd = CMD_ENQUEUE;
                    n_state = ST_OUT2;
                end
            end
            ST_BUSY_SCAN: begin
                if (i_status.bscan_done)
                    n_state = i_status.bhit ? ST_RELEASE : ST_OUT2;
                else o_cmd = CMD_BSRCH;
            end
            ST_RELEASE: begin
                o_cmd = CMD_RELEASE; o_scan_rst = 1'b1; n_state = ST_ADJ_SCAN;
            end
            ST_ADJ_SCAN: begin
                if (i_status.fscan_done) n_state = ST_MERGE;
                else o_cmd = CMD_ADJ_STEP;
            end
            ST_MERGE: begin
                o_cmd = CMD_MERGE; n_state = ST_Q_SCAN;
            end
            ST_Q_SCAN: begin
                if (i_status.qscan_done) begin
                    if (i_status.qfit) begin
                        o_cmd = CMD_QPICK; o_scan_rst = 1'b1; n_qmode = 1'b1;
                        n_state = ST_Q_FIT_SCAN;
                    end else n_state = ST_OUT1;
                end else o_cmd = CMD_QSCAN;
            end
            ST_Q_FIT_SCAN: begin
                if (i_status.busy_full || i_status.fscan_done) n_state = ST_ALLOC_DEC;
                else o_cmd = CMD_FIT_STEP;
            end
            ST_OUT1: begin
                // freed result; last unless a queued grant follows
                o_out_valid = 1'b1; o_kind = KIND_FREED; o_use_free = 1'b1;
                o_addr_en = 1'b1; o_last = !r_qmode;
                if (i_out_ready) begin
                    if (r_qmode) begin
                        o_cmd = CMD_QPOP; n_state = ST_OUT2; n_mode = 1'b0;
                    end else n_state = ST_IDLE;
                end
            end
            ST_OUT2: begin
                o_out_valid = 1'b1;
                if (r_mode) begin
                    o_kind = KIND_UNKNOWN; o_use_free = 1'b1;
                end else if (r_qmode || i_status.fit_found) begin
                    o_kind = KIND_GRANT; o_addr_en = 1'b1;
                end else if (r_drop) begin
                    o_kind = KIND_DROPPED;
                end else begin
                    o_kind = KIND_QUEUED;
                end
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/core/best_fit_partition_allocator_top.sv
// Channel | Dir | tdata (low bit up)                                   | tuser
// s_axis  | in  | process_id[7:0], request_size[24:8], pad[31:25]      | mode
// m_axis  | out | process_id[7:0], begin[23:8], end[39:24]             | kind[2:0]
// cfg     | in  | memory_size[16:0] (write enable, no read-back)       | -
// An allocate scans the free regions one per cycle; a free scans the busy,
// free and queue tables serially. One request is in flight at a time.
// Reset or a memory_size write re-inits the tables once the block is idle.
// A result holds on the output while tready is low; input waits meanwhile.
module best_fit_partition_allocator_top
    import bfpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // process_id, request_size
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // result_process, begin_address, end_address
    output logic [2:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last_result
);
`include "best_fit_partition_allocator_top_assert.svh"

    t_cmd cmd; t_status st; logic scan_rst;
    t_kind kind; logic use_free, addr_en;
    t_id cur_id, free_id; t_addr gb, ge, fb, fe;

    bfpa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_scan_rst(scan_rst),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .i_id(s_axis_tdata[7:0]),
        .i_size(s_axis_tdata[24:8]), .o_status(st), .o_cur_id(cur_id),
        .o_gb(gb), .o_ge(ge), .o_free_id(free_id), .o_fb(fb), .o_fe(fe)
    );

    bfpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_in_valid(s_axis_tvalid), .i_in_mode(s_axis_tuser),
        .i_out_ready(m_axis_tready), .i_status(st), .o_in_ready(s_axis_tready),
        .o_cmd(cmd), .o_scan_rst(scan_rst), .o_out_valid(m_axis_tvalid),
        .o_kind(kind), .o_use_free(use_free), .o_addr_en(addr_en), .o_last(m_axis_tlast)
    );

    // result formatting
    always_comb begin
        m_axis_tuser = kind;
        m_axis_tdata[7:0] = use_free ? free_id : cur_id;
        m_axis_tdata[23:8]  = !addr_en ? '0 : (use_free ? fb : gb);
        m_axis_tdata[39:24] = !addr_en ? '0 : (use_free ? fe : ge);
    end

    `BFPA_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `BFPA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid)
    `BFPA_ASSERT_IMP(a_addr_kind, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_QUEUED || m_axis_tuser == KIND_DROPPED),
        m_axis_tdata[39:8] == '0)
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bfpa_pkg::*;

    // one expected result of the allocator
    typedef struct {
        t_kind kind;
        t_id   pid;
        t_addr first_word;
        t_addr last_word;
        logic  last;
    } t_alloc_result;

    // partition table model plus expected-result queue
    class alloc_scoreboard;
        int unsigned mem_words;
        int unsigned fr_lo[$];
        int unsigned fr_hi[$];
        int unsigned bz_lo[$];
        int unsigned bz_hi[$];
        int unsigned bz_id[$];
        int unsigned wq_id[$];
        int unsigned wq_len[$];
        t_alloc_result pending[$];
        int errors;

        function void set_size(int unsigned v);
            int unsigned w;
            w = v & 17'h1ffff;
            if (w == 0) w = 1;
            if (w > 65536) w = 65536;
            mem_words = w;
            fr_lo = {0};
            fr_hi = {w - 1};
            bz_lo.delete(); bz_hi.delete(); bz_id.delete();
            wq_id.delete(); wq_len.delete();
        endfunction

        function void add_result(t_kind k, int unsigned id, int unsigned b,
                                 int unsigned e, logic last);
            t_alloc_result r;
            r.kind = k;
            r.pid = t_id'(id);
            r.first_word = t_addr'(b);
            r.last_word = t_addr'(e);
            r.last = last;
            pending.insert(pending.size(), r);
        endfunction

        // best fit; returns 0 when nothing fits or busy table full
        function bit best_fit(int unsigned id, int unsigned len,
                              output int unsigned b, output int unsigned e);
            int best;
            int unsigned waste;
            int unsigned rlen;
            int pos;
            best = -1;
            waste = 0;
            b = 0;
            e = 0;
            if (bz_id.size() >= BUSY_ENTRIES) return 0;
            foreach (fr_lo[i]) begin
                rlen = fr_hi[i] - fr_lo[i] + 1;
                if (len <= rlen && (best < 0 || rlen - len < waste)) begin
                    best = i;
                    waste = rlen - len;
                end
            end
            if (best < 0) return 0;
            b = fr_lo[best];
            e = b + len - 1;
            if (waste != 0) begin
                fr_lo[best] = e + 1;
            end else begin
                fr_lo.delete(best);
                fr_hi.delete(best);
            end
            pos = 0;
            while (pos < bz_lo.size() && bz_lo[pos] <= e) pos++;
            bz_lo.insert(pos, b);
            bz_hi.insert(pos, e);
            bz_id.insert(pos, id);
            return 1;
        endfunction

        // note an accepted request and predict its results
        function void note_request(logic free_req, int unsigned id, int unsigned len);
            int unsigned b, e, qb, qe, merged;
            int hit, up, dn, pos;
            if (!free_req) begin
                if (len == 0) len = 1;
                if (best_fit(id, len, b, e)) begin
                    add_result(KIND_GRANT, id, b, e, 1);
                end else if (wq_id.size() >= QUEUE_DEPTH) begin
                    add_result(KIND_DROPPED, id, 0, 0, 1);
                end else begin
                    wq_id.insert(wq_id.size(), id);
                    wq_len.insert(wq_len.size(), len);
                    add_result(KIND_QUEUED, id, 0, 0, 1);
                end
                return;
            end
            hit = -1;
            foreach (bz_id[i]) if (hit < 0 && bz_id[i] == id) hit = i;
            if (hit < 0) begin
                add_result(KIND_UNKNOWN, id, 0, 0, 1);
                return;
            end
            b = bz_lo[hit];
            e = bz_hi[hit];
            bz_lo.delete(hit); bz_hi.delete(hit); bz_id.delete(hit);
            up = -1;
            dn = -1;
            foreach (fr_lo[k]) begin
                if (fr_hi[k] + 1 == b) up = k;
                else if (fr_lo[k] == e + 1) dn = k;
            end
            if (up >= 0 && dn >= 0) begin
                fr_hi[up] = fr_hi[dn];
                merged = fr_hi[up] - fr_lo[up] + 1;
                fr_lo.delete(dn); fr_hi.delete(dn);
            end else if (up >= 0) begin
                fr_hi[up] = e;
                merged = fr_hi[up] - fr_lo[up] + 1;
            end else if (dn >= 0) begin
                fr_lo[dn] = b;
                merged = fr_hi[dn] - fr_lo[dn] + 1;
            end else begin
                merged = e - b + 1;
                if (fr_lo.size() < FREE_ENTRIES) begin
                    pos = 0;
                    while (pos < fr_lo.size() && fr_lo[pos] <= e) pos++;
                    fr_lo.insert(pos, b);
                    fr_hi.insert(pos, e);
                end
            end
            // retry only the first queued request that fits the merged region
            foreach (wq_len[k]) begin
                if (wq_len[k] <= merged) begin
                    if (best_fit(wq_id[k], wq_len[k], qb, qe)) begin
                        add_result(KIND_FREED, id, b, e, 0);
                        add_result(KIND_GRANT, wq_id[k], qb, qe, 1);
                        wq_id.delete(k);
                        wq_len.delete(k);
                        return;
                    end
                    break;
                end
            end
            add_result(KIND_FREED, id, b, e, 1);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(logic [2:0] kind, logic [39:0] data, logic last);
            t_alloc_result x;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind %0d data %h", kind, data));
                return;
            end
            x = pending.pop_front();
            if (kind !== x.kind)
                report($sformatf("kind %0d, expected %0d", kind, x.kind));
            if (data[7:0] !== x.pid)
                report($sformatf("process %0d, expected %0d", data[7:0], x.pid));
            if (data[23:8] !== x.first_word)
                report($sformatf("begin %h, expected %h", data[23:8], x.first_word));
            if (data[39:24] !== x.last_word)
                report($sformatf("end %h, expected %h", data[39:24], x.last_word));
            if (last !== x.last)
                report($sformatf("last %b, expected %b", last, x.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [16:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // process_id, request_size, pad
    logic        s_axis_tuser = 0;    // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;        // result_process, begin_address, end_address
    logic [2:0]  m_axis_tuser;        // result_kind
    logic        m_axis_tlast;

    alloc_scoreboard sb;
    int  idle_cycles;
    bit  hold_off = 0;
    int  held_ids[$];

    best_fit_partition_allocator_top dut (.*);

    always #5 i_clk = ~i_clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request and wait for its acceptance; valid drops on a gap
    task send_request(logic free_req, int unsigned id, int unsigned len);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= free_req;
        s_axis_tdata <= {7'd0, len[16:0], id[7:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(free_req, id, len);
        if (!free_req) held_ids.insert(held_ids.size(), id);
    endtask

    task alloc_req(int unsigned id, int unsigned len);
        send_request(0, id, len);
    endtask

    task free_req(int unsigned id);
        send_request(1, id, 0);
    endtask

    // write memory_size once all results are in and the block is quiet
    task write_size(int unsigned v);
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v[16:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_size(v);
        held_ids.delete();
        repeat (2) @(posedge i_clk);
    endtask

    // random phase: mostly allocate/free pairs with live ids, some noise
    task random_phase(int n, int unsigned max_len);
        int r, k;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                alloc_req($urandom_range(0, 255) & (r < 25 ? 8'h0f : 8'hff),
                          (r % 10 == 0) ? $urandom_range(0, 131071)
                                        : $urandom_range(0, max_len));
            end else if (r < 92 && held_ids.size() > 0) begin
                k = $urandom_range(0, held_ids.size() - 1);
                free_req(held_ids[k]);
                held_ids.delete(k);
            end else begin
                free_req($urandom_range(0, 255));
            end
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        sb.set_size(65536);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, exact fit, queueing, coalescing, unknown id
        alloc_req(8'h00, 0);
        alloc_req(8'hff, 65536);
        alloc_req(8'h55, 65535);
        free_req(8'h00);
        free_req(8'h00);
        free_req(8'h55);
        alloc_req(8'haa, 131071);
        alloc_req(8'h01, 16);
        alloc_req(8'h01, 16);
        free_req(8'h01);
        free_req(8'h01);
        write_size(0);
        alloc_req(8'h02, 1);
        alloc_req(8'h03, 1);
        for (int i = 0; i < 8; i++) alloc_req(8'h10 + i, 2);
        free_req(8'h02);
        free_req(8'h99);

        // small memory: busy table full and queue pressure
        write_size(40);
        for (int i = 0; i < 18; i++) alloc_req(i, 2);
        hold_off = 1;
        random_phase(30, 8);
        random_phase(300, 12);
        write_size(131071);
        random_phase(200, 20000);
        write_size(1000);
        random_phase(300, 150);
        write_size(65536);
        random_phase(60, 70000);

        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bfpa_pkg.sv
rtl/core/bfpa_datapath.sv
rtl/core/bfpa_ctrl.sv
rtl/core/best_fit_partition_allocator_top.sv
verif/tb_top.sv
